/* sv/assert_macros.svh */
// Assertion macros shared by the slot map RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define NFHSM_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define NFHSM_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/nfhsm_pkg.sv */
// Types and codes shared by the next-fit handle slot map.
package nfhsm_pkg;

  localparam int SLOT_W   = 8;
  localparam int HANDLE_W = 31;

  typedef enum logic [1:0] {
    MODE_ALLOC  = 2'd0,
    MODE_FREE   = 2'd1,
    MODE_LOOKUP = 2'd2,
    MODE_NONE   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_UNUSED = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_CHECK
  } state_t;

  typedef struct packed {
    logic use_we;
    logic use_wdata;
    logic hdl_we;
  } mem_ctl_t;

endpackage

/* sv/nfhsm_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
module nfhsm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sv/nfhsm_ctrl.sv */
// Sequencer for the slot map: clearing pass, next-fit scan, free and look up.
`include "assert_macros.svh"
module nfhsm_ctrl
  import nfhsm_pkg::*;
#(
  parameter int SLOTS    = 256,
  parameter int RESERVED = 3
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [1:0]               in_mode,
  input  logic [HANDLE_W-1:0]      in_handle_in,
  input  logic [SLOT_W-1:0]        in_slot_in,
  output logic                     out_strobe,
  output logic [1:0]               out_status,
  output logic [SLOT_W-1:0]        out_slot_out,
  output logic [HANDLE_W-1:0]      out_handle_out,
  output mem_ctl_t                 mem_ctl,
  output logic [$clog2(SLOTS)-1:0] waddr,
  output logic [$clog2(SLOTS)-1:0] raddr,
  output logic [HANDLE_W-1:0]      hdl_wdata,
  input  logic                     use_rdata,
  input  logic [HANDLE_W-1:0]      hdl_rdata
);

  localparam int AW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);
  localparam logic [AW-1:0] LAST = AW'(SLOTS - 1);

  state_t               state_r, state_nxt;
  mode_t                mode_r, mode_nxt;
  logic [HANDLE_W-1:0]  handle_r, handle_nxt;
  logic [SLOT_W-1:0]    slot_r, slot_nxt;
  logic [AW-1:0]        pos_r, pos_nxt;
  logic [AW-1:0]        scan_r, scan_nxt;
  logic [AW-1:0]        next_ptr_r, next_ptr_nxt;
  logic [CW-1:0]        count_r, count_nxt;
  logic [AW-1:0]        clr_r, clr_nxt;
  logic                 strobe_r, strobe_nxt;
  status_t              status_r, status_nxt;
  logic [SLOT_W-1:0]    oslot_r, oslot_nxt;
  logic [HANDLE_W-1:0]  ohandle_r, ohandle_nxt;

  logic                 slot_ok;
  logic [AW-1:0]        slot_idx;
  logic [AW-1:0]        pos_inc;

  assign slot_ok  = 32'(in_slot_in) < 32'(SLOTS);
  assign slot_idx = AW'(in_slot_in);
  assign pos_inc  = (pos_r == LAST) ? '0 : pos_r + AW'(1);

  assign busy           = (state_r != S_IDLE);
  assign hdl_wdata      = handle_r;
  assign out_strobe     = strobe_r;
  assign out_status     = status_r;
  assign out_slot_out   = oslot_r;
  assign out_handle_out = ohandle_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLEAR;
      clr_r      <= '0;
      next_ptr_r <= AW'(RESERVED % SLOTS);
      count_r    <= CW'(RESERVED);
      strobe_r   <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      clr_r      <= clr_nxt;
      next_ptr_r <= next_ptr_nxt;
      count_r    <= count_nxt;
      strobe_r   <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r    <= mode_nxt;
    handle_r  <= handle_nxt;
    slot_r    <= slot_nxt;
    pos_r     <= pos_nxt;
    scan_r    <= scan_nxt;
    status_r  <= status_nxt;
    oslot_r   <= oslot_nxt;
    ohandle_r <= ohandle_nxt;
  end

  always_comb begin
    state_nxt    = state_r;
    mode_nxt     = mode_r;
    handle_nxt   = handle_r;
    slot_nxt     = slot_r;
    pos_nxt      = pos_r;
    scan_nxt     = scan_r;
    next_ptr_nxt = next_ptr_r;
    count_nxt    = count_r;
    clr_nxt      = clr_r;
    strobe_nxt   = 1'b0;
    status_nxt   = status_r;
    oslot_nxt    = oslot_r;
    ohandle_nxt  = ohandle_r;
    mem_ctl      = '0;
    waddr        = pos_r;
    raddr        = pos_r;

    unique case (state_r)
      S_CLEAR: begin
        mem_ctl.use_we    = 1'b1;
        mem_ctl.use_wdata = (32'(clr_r) < 32'(RESERVED));
        waddr             = clr_r;
        clr_nxt           = clr_r + AW'(1);
        if (clr_r == LAST) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          mode_nxt    = mode_t'(in_mode);
          handle_nxt  = in_handle_in;
          slot_nxt    = in_slot_in;
          oslot_nxt   = in_slot_in;
          ohandle_nxt = '0;
          status_nxt  = ST_OK;
          unique case (mode_t'(in_mode))
            MODE_ALLOC: begin
              if (32'(count_r) >= 32'(SLOTS)) begin
                strobe_nxt = 1'b1;
                status_nxt = ST_FULL;
              end else begin
                raddr     = next_ptr_r;
                pos_nxt   = next_ptr_r;
                scan_nxt  = '0;
                state_nxt = S_SCAN;
              end
            end
            MODE_FREE, MODE_LOOKUP: begin
              if (!slot_ok) begin
                strobe_nxt = 1'b1;
                status_nxt = ST_UNUSED;
              end else begin
                raddr     = slot_idx;
                pos_nxt   = slot_idx;
                state_nxt = S_CHECK;
              end
            end
            MODE_NONE: begin
              strobe_nxt = 1'b1;
            end
            default: begin
              strobe_nxt = 1'b1;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (!use_rdata) begin
          mem_ctl.use_we    = 1'b1;
          mem_ctl.use_wdata = 1'b1;
          mem_ctl.hdl_we    = 1'b1;
          next_ptr_nxt      = pos_inc;
          count_nxt         = count_r + CW'(1);
          strobe_nxt        = 1'b1;
          status_nxt        = ST_OK;
          oslot_nxt         = SLOT_W'(pos_r);
          state_nxt         = S_IDLE;
        end else if (scan_r == LAST) begin
          strobe_nxt = 1'b1;
          status_nxt = ST_FULL;
          state_nxt  = S_IDLE;
        end else begin
          raddr    = pos_inc;
          pos_nxt  = pos_inc;
          scan_nxt = scan_r + AW'(1);
        end
      end
      S_CHECK: begin
        strobe_nxt = 1'b1;
        state_nxt  = S_IDLE;
        if (!use_rdata) begin
          status_nxt = ST_UNUSED;
        end else if (mode_r == MODE_FREE) begin
          mem_ctl.use_we    = 1'b1;
          mem_ctl.use_wdata = 1'b0;
          if (count_r != '0) begin
            count_nxt = count_r - CW'(1);
          end
        end else begin
          ohandle_nxt = hdl_rdata;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  `NFHSM_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, 32'(count_r) <= 32'(SLOTS),
                    "Used count exceeds the table size.")
  `NFHSM_ASSERT_IMP(a_strobe_idle, clk, rst_n, strobe_r, state_r == S_IDLE,
                    "Result strobe while the sequencer is not idle.")
  `NFHSM_ASSERT_NXT(a_accept_progress, clk, rst_n, start && !busy,
                    busy || strobe_r, "Accepted word neither started nor answered.")
  `NFHSM_ASSERT_IMP(a_no_write_idle, clk, rst_n, state_r == S_IDLE,
                    !mem_ctl.use_we && !mem_ctl.hdl_we,
                    "Memory write while the sequencer is idle.")

endmodule

/* sv/next_fit_handle_slot_map.sv */
// Next-fit handle slot map: top level with in-use and handle memories.
// After reset a clearing pass initializes the in-use memory; busy is high.
// Free, look up: S_CHECK, then the registered result strobe; next word accepted with the strobe.
// Allocate: the scan visits k slots (1 to SLOTS) from the next-fit pointer before the result.
// Full table, slot beyond the table and unused mode: strobe in the cycle after acceptance.
// The scan reads one in-use bit a cycle from the in-use memory; results cannot be stalled.
module next_fit_handle_slot_map
  import nfhsm_pkg::*;
#(
  parameter int SLOTS    = 256,
  parameter int RESERVED = 3
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          in_mode,
  input  logic [HANDLE_W-1:0] in_handle_in,
  input  logic [SLOT_W-1:0]   in_slot_in,
  output logic                out_strobe,
  output logic [1:0]          out_status,
  output logic [SLOT_W-1:0]   out_slot_out,
  output logic [HANDLE_W-1:0] out_handle_out
);

  localparam int AW = $clog2(SLOTS);

  mem_ctl_t            mem_ctl;
  logic [AW-1:0]       waddr;
  logic [AW-1:0]       raddr;
  logic [HANDLE_W-1:0] hdl_wdata;
  logic                use_rdata;
  logic [HANDLE_W-1:0] hdl_rdata;

  nfhsm_ctrl #(
    .SLOTS    (SLOTS),
    .RESERVED (RESERVED)
  ) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_mode        (in_mode),
    .in_handle_in   (in_handle_in),
    .in_slot_in     (in_slot_in),
    .out_strobe     (out_strobe),
    .out_status     (out_status),
    .out_slot_out   (out_slot_out),
    .out_handle_out (out_handle_out),
    .mem_ctl        (mem_ctl),
    .waddr          (waddr),
    .raddr          (raddr),
    .hdl_wdata      (hdl_wdata),
    .use_rdata      (use_rdata),
    .hdl_rdata      (hdl_rdata)
  );

  nfhsm_ram #(
    .WIDTH (1),
    .DEPTH (SLOTS)
  ) u_use_ram (
    .clk   (clk),
    .we    (mem_ctl.use_we),
    .waddr (waddr),
    .wdata (mem_ctl.use_wdata),
    .raddr (raddr),
    .rdata (use_rdata)
  );

  nfhsm_ram #(
    .WIDTH (HANDLE_W),
    .DEPTH (SLOTS)
  ) u_hdl_ram (
    .clk   (clk),
    .we    (mem_ctl.hdl_we),
    .waddr (waddr),
    .wdata (hdl_wdata),
    .raddr (raddr),
    .rdata (hdl_rdata)
  );

endmodule
